// ----- hdl/lit_pkg.sv -----
// Shared definitions for the live interval table: command, status and kind codes,
// port field widths and parameter defaults.
// Depends on nothing; used by the top level, its checker and the testbench.
package lit_pkg;

   localparam int REGS_DEFAULT     = 256;
   localparam int ID_WIDTH_DEFAULT = 16;

   localparam int CMD_W     = 3;
   localparam int IDX_W     = 8;
   localparam int ID_PORT_W = 16;
   localparam int KIND_W    = 2;
   localparam int REAL_W    = 5;
   localparam int STATUS_W  = 2;

   localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_LIVE_OUT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_USE      = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DEF      = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ     = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_CONFLICT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_REAL     = 2'd2;

   localparam logic [KIND_W-1:0] KIND_UNSET = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FIXED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_VIRT  = 2'd2;

   localparam logic [KIND_W-1:0] OP_VIRT  = 2'd0;
   localparam logic [KIND_W-1:0] OP_FIXED = 2'd1;

endpackage

// ----- hdl/live_interval_table_unit.sv -----
// Live interval table: one interval per virtual register, kept in one RAM word per entry.
// Depends on lit_pkg and lit_ram.
//
// A command is taken when start is high and busy is low. Its result is driven on the rsp_
// ports for one cycle, marked by rsp_strobe, after passing the s1 stage register and the
// response registers. Live-out, use, def and read each read their entry from the table RAM;
// live-out, and a use or def whose status is ok, write it back. These commands can be
// issued every cycle while busy is low; a write forwarded from the previous command
// covers back-to-back commands on the same register. Clear, and reset, run a sweep that
// writes one RAM entry per cycle and holds busy high until the last entry is written. The
// receiver cannot stall: every result beat must be taken in the cycle it is shown.
module live_interval_table_unit #(
   parameter int REGS     = lit_pkg::REGS_DEFAULT,
   parameter int ID_WIDTH = lit_pkg::ID_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [lit_pkg::CMD_W-1:0]     req_cmd,
   input  logic [lit_pkg::IDX_W-1:0]     req_reg_index,
   input  logic [lit_pkg::ID_PORT_W-1:0] req_range_start,
   input  logic [lit_pkg::ID_PORT_W-1:0] req_range_end,
   input  logic [lit_pkg::KIND_W-1:0]    req_reg_kind,
   input  logic [lit_pkg::REAL_W-1:0]    req_real_reg,
   output logic                          rsp_strobe,
   output logic [lit_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_start_valid,
   output logic [lit_pkg::ID_PORT_W-1:0] rsp_start_point,
   output logic                          rsp_end_valid,
   output logic [lit_pkg::ID_PORT_W-1:0] rsp_end_point,
   output logic [lit_pkg::KIND_W-1:0]    rsp_entry_kind,
   output logic [lit_pkg::REAL_W-1:0]    rsp_bound_real
);

   localparam int IdPortW = lit_pkg::ID_PORT_W;
   localparam int Sw      = (ID_WIDTH < IdPortW) ? ID_WIDTH : IdPortW;
   localparam int Aw      = $clog2(REGS);
   localparam int ExtW    = 13;

   typedef struct packed {
      logic [lit_pkg::REAL_W-1:0] real_reg;
      logic [lit_pkg::KIND_W-1:0] kind;
      logic                       end_set;
      logic                       start_set;
      logic [Sw-1:0]              end_point;
      logic [Sw-1:0]              start_point;
   } entry_type;

   localparam int Ww = $bits(entry_type);

   logic [ExtW-1:0] idx_ext;
   logic [Aw-1:0]   req_addr;
   logic            req_inrange;
   logic            accept;

   logic          sweep_active_ff, sweep_active_in;
   logic [Aw-1:0] sweep_addr_ff, sweep_addr_in;

   logic                         s1_valid_ff, s1_valid_in;
   logic [lit_pkg::CMD_W-1:0]    s1_cmd_ff, s1_cmd_in;
   logic [Aw-1:0]                s1_addr_ff, s1_addr_in;
   logic                         s1_inrange_ff, s1_inrange_in;
   logic [Sw-1:0]                s1_rs_ff, s1_rs_in;
   logic [Sw-1:0]                s1_re_ff, s1_re_in;
   logic [lit_pkg::KIND_W-1:0]   s1_kind_ff, s1_kind_in;
   logic [lit_pkg::REAL_W-1:0]   s1_real_ff, s1_real_in;

   logic          fwd_valid_ff, fwd_valid_in;
   logic [Aw-1:0] fwd_addr_ff, fwd_addr_in;
   entry_type     fwd_word_ff, fwd_word_in;

   logic                          rsp_strobe_ff, rsp_strobe_in;
   logic [lit_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic                          rsp_start_valid_ff, rsp_start_valid_in;
   logic [IdPortW-1:0]            rsp_start_point_ff, rsp_start_point_in;
   logic                          rsp_end_valid_ff, rsp_end_valid_in;
   logic [IdPortW-1:0]            rsp_end_point_ff, rsp_end_point_in;
   logic [lit_pkg::KIND_W-1:0]    rsp_entry_kind_ff, rsp_entry_kind_in;
   logic [lit_pkg::REAL_W-1:0]    rsp_bound_real_ff, rsp_bound_real_in;

   logic [Ww-1:0]               ram_rd_data;
   logic                        ram_wr_en;
   logic [Aw-1:0]               ram_wr_addr;
   logic [Ww-1:0]               ram_wr_data;

   entry_type                   cur;
   entry_type                   nxt;
   entry_type                   widened;
   entry_type                   applied;
   logic [lit_pkg::STATUS_W-1:0] check_status;
   logic                        s1_wr;

   assign busy        = sweep_active_ff || reset;
   assign accept      = start && !busy;
   assign idx_ext     = {{(ExtW - lit_pkg::IDX_W){1'b0}}, req_reg_index};
   assign req_addr    = idx_ext[Aw-1:0];
   assign req_inrange = idx_ext < ExtW'(REGS);

   lit_ram #(
      .WIDTH(Ww),
      .DEPTH(REGS)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(req_addr),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      sweep_active_in = sweep_active_ff;
      sweep_addr_in   = sweep_addr_ff;
      if (sweep_active_ff) begin
         sweep_addr_in = sweep_addr_ff + Aw'(1);
         if (sweep_addr_ff == Aw'(REGS - 1)) begin
            sweep_active_in = 1'b0;
            sweep_addr_in   = '0;
         end
      end else if (accept && req_cmd == lit_pkg::CMD_CLEAR) begin
         sweep_active_in = 1'b1;
         sweep_addr_in   = '0;
      end
   end

   always_comb begin
      s1_valid_in   = accept;
      s1_cmd_in     = accept ? req_cmd : s1_cmd_ff;
      s1_addr_in    = accept ? req_addr : s1_addr_ff;
      s1_inrange_in = accept ? req_inrange : s1_inrange_ff;
      s1_rs_in      = accept ? req_range_start[Sw-1:0] : s1_rs_ff;
      s1_re_in      = accept ? req_range_end[Sw-1:0] : s1_re_ff;
      s1_kind_in    = accept ? req_reg_kind : s1_kind_ff;
      s1_real_in    = accept ? req_real_reg : s1_real_ff;
   end

   always_comb begin
      if (fwd_valid_ff && fwd_addr_ff == s1_addr_ff) begin
         cur = fwd_word_ff;
      end else begin
         cur = entry_type'(ram_rd_data);
      end

      widened = cur;
      if (!cur.start_set || cur.start_point > s1_rs_ff) begin
         widened.start_point = s1_rs_ff;
      end
      if (!cur.end_set || cur.end_point < s1_re_ff) begin
         widened.end_point = s1_re_ff;
      end
      widened.start_set = 1'b1;
      widened.end_set   = 1'b1;

      if (s1_kind_ff == lit_pkg::OP_FIXED) begin
         check_status = (cur.kind == lit_pkg::KIND_VIRT) ? lit_pkg::ST_CONFLICT : lit_pkg::ST_OK;
      end else if (s1_kind_ff == lit_pkg::OP_VIRT) begin
         check_status = (cur.kind == lit_pkg::KIND_FIXED) ? lit_pkg::ST_CONFLICT : lit_pkg::ST_OK;
      end else begin
         check_status = lit_pkg::ST_REAL;
      end

      applied = cur;
      if (s1_cmd_ff == lit_pkg::CMD_USE) begin
         applied = widened;
      end else begin
         applied.start_point = s1_rs_ff;
         applied.start_set   = 1'b1;
      end
      if (s1_kind_ff == lit_pkg::OP_FIXED) begin
         applied.kind     = lit_pkg::KIND_FIXED;
         applied.real_reg = s1_real_ff;
      end else begin
         applied.kind = lit_pkg::KIND_VIRT;
      end

      nxt                = cur;
      s1_wr              = 1'b0;
      rsp_status_in      = lit_pkg::ST_OK;
      rsp_start_valid_in = 1'b0;
      rsp_start_point_in = '0;
      rsp_end_valid_in   = 1'b0;
      rsp_end_point_in   = '0;
      rsp_entry_kind_in  = lit_pkg::KIND_UNSET;
      rsp_bound_real_in  = '0;

      if (s1_inrange_ff) begin
         unique case (s1_cmd_ff)
            lit_pkg::CMD_LIVE_OUT: begin
               nxt   = widened;
               s1_wr = 1'b1;
            end
            lit_pkg::CMD_USE: begin
               rsp_status_in = check_status;
               nxt           = applied;
               s1_wr         = (check_status == lit_pkg::ST_OK);
            end
            lit_pkg::CMD_DEF: begin
               rsp_status_in = check_status;
               nxt           = applied;
               s1_wr         = (check_status == lit_pkg::ST_OK);
            end
            lit_pkg::CMD_READ: begin
               rsp_start_valid_in = cur.start_set;
               rsp_start_point_in = cur.start_set ? IdPortW'(cur.start_point) : '0;
               rsp_end_valid_in   = cur.end_set;
               rsp_end_point_in   = cur.end_set ? IdPortW'(cur.end_point) : '0;
               rsp_entry_kind_in  = cur.kind;
               rsp_bound_real_in  = (cur.kind == lit_pkg::KIND_FIXED) ? cur.real_reg : '0;
            end
            default: begin
               nxt = cur;
            end
         endcase
      end
      s1_wr         = s1_wr && s1_valid_ff;
      rsp_strobe_in = s1_valid_ff;
   end

   always_comb begin
      if (sweep_active_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = sweep_addr_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = s1_wr;
         ram_wr_addr = s1_addr_ff;
         ram_wr_data = nxt;
      end
   end

   always_comb begin
      fwd_valid_in = fwd_valid_ff;
      fwd_addr_in  = fwd_addr_ff;
      fwd_word_in  = fwd_word_ff;
      if (sweep_active_ff) begin
         fwd_valid_in = 1'b0;
      end else if (s1_wr) begin
         fwd_valid_in = 1'b1;
         fwd_addr_in  = s1_addr_ff;
         fwd_word_in  = nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_active_ff <= 1'b1;
         sweep_addr_ff   <= '0;
         s1_valid_ff     <= 1'b0;
         fwd_valid_ff    <= 1'b0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         sweep_active_ff <= sweep_active_in;
         sweep_addr_ff   <= sweep_addr_in;
         s1_valid_ff     <= s1_valid_in;
         fwd_valid_ff    <= fwd_valid_in;
         rsp_strobe_ff   <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff          <= s1_cmd_in;
      s1_addr_ff         <= s1_addr_in;
      s1_inrange_ff      <= s1_inrange_in;
      s1_rs_ff           <= s1_rs_in;
      s1_re_ff           <= s1_re_in;
      s1_kind_ff         <= s1_kind_in;
      s1_real_ff         <= s1_real_in;
      fwd_addr_ff        <= fwd_addr_in;
      fwd_word_ff        <= fwd_word_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_start_valid_ff <= rsp_start_valid_in;
      rsp_start_point_ff <= rsp_start_point_in;
      rsp_end_valid_ff   <= rsp_end_valid_in;
      rsp_end_point_ff   <= rsp_end_point_in;
      rsp_entry_kind_ff  <= rsp_entry_kind_in;
      rsp_bound_real_ff  <= rsp_bound_real_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_start_valid = rsp_start_valid_ff;
   assign rsp_start_point = rsp_start_point_ff;
   assign rsp_end_valid   = rsp_end_valid_ff;
   assign rsp_end_point   = rsp_end_point_ff;
   assign rsp_entry_kind  = rsp_entry_kind_ff;
   assign rsp_bound_real  = rsp_bound_real_ff;

endmodule

// ----- hdl/lit_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module lit_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/lit_checker.sv -----
// Port-level checks for the live interval table, bound to the top level.
// Depends on lit_pkg and live_interval_table_unit.
module lit_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [lit_pkg::CMD_W-1:0]     req_cmd,
   input logic                          rsp_strobe,
   input logic                          rsp_start_valid,
   input logic [lit_pkg::ID_PORT_W-1:0] rsp_start_point,
   input logic                          rsp_end_valid,
   input logic [lit_pkg::ID_PORT_W-1:0] rsp_end_point,
   input logic [lit_pkg::KIND_W-1:0]    rsp_entry_kind,
   input logic [lit_pkg::REAL_W-1:0]    rsp_bound_real
);

   logic accept;

   assign accept = start && !busy;

   // Every accepted command produces a result beat, through the s1 stage and response registers.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_strobe)
      else $error("accepted command produced no result beat");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 2))
      else $error("result beat without an accepted command");

   a_nonread_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(req_cmd, 2) != lit_pkg::CMD_READ |->
         !rsp_start_valid && rsp_start_point == '0 && !rsp_end_valid &&
         rsp_end_point == '0 && rsp_entry_kind == lit_pkg::KIND_UNSET &&
         rsp_bound_real == '0)
      else $error("entry fields set on a result that is not a read");

   a_clear_sweeps: assert property (@(posedge clock) disable iff (reset)
      accept && req_cmd == lit_pkg::CMD_CLEAR |=> busy)
      else $error("clear did not start the table sweep");

   a_fields_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_start_valid || rsp_start_point == '0) &&
         (rsp_end_valid || rsp_end_point == '0) &&
         (rsp_entry_kind == lit_pkg::KIND_FIXED || rsp_bound_real == '0))
      else $error("entry value shown without its valid flag or fixed kind");

endmodule

bind live_interval_table_unit lit_checker u_lit_checker (.*);

// ----- sim/live_interval_table_unit_test.sv -----
// Self-checking testbench for live_interval_table_unit: directed and random commands.
// It predicts each result beat from its own copy of the interval table.
// Depends on lit_pkg and the live_interval_table_unit RTL.
`timescale 1ns / 1ps

module live_interval_table_unit_test;

   localparam logic [lit_pkg::CMD_W-1:0]  CMD_UNUSED_FIRST = 3'd5;
   localparam logic [lit_pkg::CMD_W-1:0]  CMD_UNUSED_LAST  = 3'd7;
   localparam logic [lit_pkg::KIND_W-1:0] OP_REAL_REG      = 2'd2;
   localparam logic [lit_pkg::KIND_W-1:0] OP_UNDEF         = 2'd3;
   localparam int                         TABLE_SIZE       = lit_pkg::REGS_DEFAULT;

   typedef struct {
      logic [lit_pkg::CMD_W-1:0]     cmd;
      logic [lit_pkg::IDX_W-1:0]     idx;
      logic [lit_pkg::ID_PORT_W-1:0] span_from;
      logic [lit_pkg::ID_PORT_W-1:0] span_to;
      logic [lit_pkg::KIND_W-1:0]    kind;
      logic [lit_pkg::REAL_W-1:0]    phys;
      int                            gap;
      bit                            drain;
   } command_type;

   typedef struct packed {
      logic [lit_pkg::STATUS_W-1:0]  status;
      logic                          start_valid;
      logic [lit_pkg::ID_PORT_W-1:0] start_point;
      logic                          end_valid;
      logic [lit_pkg::ID_PORT_W-1:0] end_point;
      logic [lit_pkg::KIND_W-1:0]    entry_kind;
      logic [lit_pkg::REAL_W-1:0]    bound_real;
   } entry_report_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [lit_pkg::CMD_W-1:0]     req_cmd = lit_pkg::CMD_READ;
   logic [lit_pkg::IDX_W-1:0]     req_reg_index = '0;
   logic [lit_pkg::ID_PORT_W-1:0] req_range_start = '0;
   logic [lit_pkg::ID_PORT_W-1:0] req_range_end = '0;
   logic [lit_pkg::KIND_W-1:0]    req_reg_kind = lit_pkg::OP_VIRT;
   logic [lit_pkg::REAL_W-1:0]    req_real_reg = '0;
   logic                          rsp_strobe;
   logic [lit_pkg::STATUS_W-1:0]  rsp_status;
   logic                          rsp_start_valid;
   logic [lit_pkg::ID_PORT_W-1:0] rsp_start_point;
   logic                          rsp_end_valid;
   logic [lit_pkg::ID_PORT_W-1:0] rsp_end_point;
   logic [lit_pkg::KIND_W-1:0]    rsp_entry_kind;
   logic [lit_pkg::REAL_W-1:0]    rsp_bound_real;

   // Predicted table contents.
   logic [lit_pkg::ID_PORT_W-1:0] iv_start [TABLE_SIZE];
   logic [lit_pkg::ID_PORT_W-1:0] iv_end [TABLE_SIZE];
   bit                            iv_start_set [TABLE_SIZE];
   bit                            iv_end_set [TABLE_SIZE];
   logic [lit_pkg::KIND_W-1:0]    iv_kind [TABLE_SIZE];
   logic [lit_pkg::REAL_W-1:0]    iv_phys [TABLE_SIZE];

   command_type      cmd_queue[$];
   entry_report_type pending_reports[$];
   int               errors = 0;
   bit               beat_taken = 1'b0;
   int               gap_left = 0;
   bit               gap_loaded = 1'b0;

   live_interval_table_unit u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cmd(req_cmd),
      .req_reg_index(req_reg_index),
      .req_range_start(req_range_start),
      .req_range_end(req_range_end),
      .req_reg_kind(req_reg_kind),
      .req_real_reg(req_real_reg),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_start_valid(rsp_start_valid),
      .rsp_start_point(rsp_start_point),
      .rsp_end_valid(rsp_end_valid),
      .rsp_end_point(rsp_end_point),
      .rsp_entry_kind(rsp_entry_kind),
      .rsp_bound_real(rsp_bound_real)
   );

   always #5 clock = ~clock;

   function automatic command_type make_cmd(logic [lit_pkg::CMD_W-1:0] cmd,
                                            logic [lit_pkg::IDX_W-1:0] idx,
                                            logic [lit_pkg::ID_PORT_W-1:0] span_from,
                                            logic [lit_pkg::ID_PORT_W-1:0] span_to,
                                            logic [lit_pkg::KIND_W-1:0] kind,
                                            logic [lit_pkg::REAL_W-1:0] phys);
      command_type c;
      c.cmd = cmd;
      c.idx = idx;
      c.span_from = span_from;
      c.span_to = span_to;
      c.kind = kind;
      c.phys = phys;
      c.gap = 0;
      c.drain = 1'b0;
      return c;
   endfunction

   function automatic void widen_interval(int idx, logic [lit_pkg::ID_PORT_W-1:0] lo,
                                          logic [lit_pkg::ID_PORT_W-1:0] hi);
      if (!iv_start_set[idx] || iv_start[idx] > lo) begin
         iv_start[idx] = lo;
         iv_start_set[idx] = 1'b1;
      end
      if (!iv_end_set[idx] || iv_end[idx] < hi) begin
         iv_end[idx] = hi;
         iv_end_set[idx] = 1'b1;
      end
   endfunction

   function automatic logic [lit_pkg::STATUS_W-1:0] kind_status(int idx,
                                                                logic [lit_pkg::KIND_W-1:0] op);
      if (op == lit_pkg::OP_FIXED) begin
         return (iv_kind[idx] == lit_pkg::KIND_VIRT) ? lit_pkg::ST_CONFLICT : lit_pkg::ST_OK;
      end
      if (op == lit_pkg::OP_VIRT) begin
         return (iv_kind[idx] == lit_pkg::KIND_FIXED) ? lit_pkg::ST_CONFLICT : lit_pkg::ST_OK;
      end
      return lit_pkg::ST_REAL;
   endfunction

   function automatic void bind_kind(int idx, logic [lit_pkg::KIND_W-1:0] op,
                                     logic [lit_pkg::REAL_W-1:0] phys);
      if (op == lit_pkg::OP_FIXED) begin
         iv_kind[idx] = lit_pkg::KIND_FIXED;
         iv_phys[idx] = phys;
      end else begin
         iv_kind[idx] = lit_pkg::KIND_VIRT;
      end
   endfunction

   // Applies one command to the predicted table and returns the beat it must produce.
   function automatic entry_report_type table_step(command_type c);
      entry_report_type r;
      int idx;
      r = '0;
      idx = int'(c.idx);
      case (c.cmd)
         lit_pkg::CMD_CLEAR: begin
            for (int i = 0; i < TABLE_SIZE; i++) begin
               iv_start_set[i] = 1'b0;
               iv_end_set[i] = 1'b0;
               iv_kind[i] = lit_pkg::KIND_UNSET;
            end
         end
         lit_pkg::CMD_LIVE_OUT: widen_interval(idx, c.span_from, c.span_to);
         lit_pkg::CMD_USE: begin
            r.status = kind_status(idx, c.kind);
            if (r.status == lit_pkg::ST_OK) begin
               widen_interval(idx, c.span_from, c.span_to);
               bind_kind(idx, c.kind, c.phys);
            end
         end
         lit_pkg::CMD_DEF: begin
            r.status = kind_status(idx, c.kind);
            if (r.status == lit_pkg::ST_OK) begin
               iv_start[idx] = c.span_from;
               iv_start_set[idx] = 1'b1;
               bind_kind(idx, c.kind, c.phys);
            end
         end
         lit_pkg::CMD_READ: begin
            r.start_valid = iv_start_set[idx];
            r.start_point = iv_start_set[idx] ? iv_start[idx] : '0;
            r.end_valid = iv_end_set[idx];
            r.end_point = iv_end_set[idx] ? iv_end[idx] : '0;
            r.entry_kind = iv_kind[idx];
            r.bound_real = (iv_kind[idx] == lit_pkg::KIND_FIXED) ? iv_phys[idx] : '0;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic check_field(string name, logic [lit_pkg::ID_PORT_W-1:0] want,
                              logic [lit_pkg::ID_PORT_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   // Monitor: checks result beats, then records any command beat taken at this edge.
   always @(posedge clock) begin
      entry_report_type want;
      if (reset) begin
         beat_taken = 1'b0;
      end else begin
         if (rsp_strobe) begin
            if (pending_reports.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, actual status %0h",
                        $time, rsp_status);
               errors++;
            end else begin
               want = pending_reports.pop_front();
               check_field("status", 16'(want.status), 16'(rsp_status));
               check_field("start_valid", 16'(want.start_valid), 16'(rsp_start_valid));
               check_field("start_point", want.start_point, rsp_start_point);
               check_field("end_valid", 16'(want.end_valid), 16'(rsp_end_valid));
               check_field("end_point", want.end_point, rsp_end_point);
               check_field("entry_kind", 16'(want.entry_kind), 16'(rsp_entry_kind));
               check_field("bound_real", 16'(want.bound_real), 16'(rsp_bound_real));
            end
         end
         beat_taken = start && !busy;
         if (beat_taken) begin
            pending_reports.push_back(table_step(make_cmd(req_cmd, req_reg_index,
               req_range_start, req_range_end, req_reg_kind, req_real_reg)));
         end
      end
   end

   // Driver: holds a beat until it is taken, then applies the next gap and beat.
   always @(negedge clock) begin
      command_type nxt;
      bit go;
      if (!reset && !(start && !beat_taken)) begin
         go = 1'b0;
         if (cmd_queue.size() != 0) begin
            if (!gap_loaded) begin
               gap_left = cmd_queue[0].gap;
               gap_loaded = 1'b1;
            end
            if (gap_left > 0) begin
               gap_left--;
            end else if (!(cmd_queue[0].drain && pending_reports.size() != 0)) begin
               nxt = cmd_queue.pop_front();
               gap_loaded = 1'b0;
               go = 1'b1;
               req_cmd <= nxt.cmd;
               req_reg_index <= nxt.idx;
               req_range_start <= nxt.span_from;
               req_range_end <= nxt.span_to;
               req_reg_kind <= nxt.kind;
               req_real_reg <= nxt.phys;
            end
         end
         start <= go;
      end
   end

   initial begin
      command_type c;
      logic [lit_pkg::IDX_W-1:0] pool [8];
      logic [lit_pkg::ID_PORT_W-1:0] lo, hi, tmp;
      logic [lit_pkg::CMD_W-1:0] op;
      logic [lit_pkg::KIND_W-1:0] kind;
      int pick, slot;

      cmd_queue.push_back(make_cmd(lit_pkg::CMD_READ, 8'd0, 16'h0000, 16'h0000,
                                   lit_pkg::OP_VIRT, 5'd0));
      cmd_queue.push_back(make_cmd(lit_pkg::CMD_LIVE_OUT, 8'd255, 16'h0000, 16'hFFFF,
                                   OP_UNDEF, 5'd31));
      cmd_queue.push_back(make_cmd(lit_pkg::CMD_READ, 8'd255, 16'hFFFF, 16'hFFFF,
                                   OP_UNDEF, 5'd31));
      cmd_queue.push_back(make_cmd(lit_pkg::CMD_LIVE_OUT, 8'd255, 16'h8000, 16'h7FFF,
                                   lit_pkg::OP_FIXED, 5'd1));
      cmd_queue.push_back(make_cmd(lit_pkg::CMD_READ, 8'd255, 16'h0000, 16'h0000,
                                   lit_pkg::OP_VIRT, 5'd0));
      cmd_queue.push_back(make_cmd(lit_pkg::CMD_USE, 8'd1, 16'd100, 16'd200,
                                   lit_pkg::OP_VIRT, 5'd0));
      cmd_queue.push_back(make_cmd(lit_pkg::CMD_USE, 8'd1, 16'd50, 16'd150,
                                   lit_pkg::OP_VIRT, 5'd0));
      cmd_queue.push_back(make_cmd(lit_pkg::CMD_READ, 8'd1, 16'd0, 16'd0,
                                   lit_pkg::OP_VIRT, 5'd0));
      cmd_queue.push_back(make_cmd(lit_pkg::CMD_USE, 8'd1, 16'd0, 16'd900,
                                   lit_pkg::OP_FIXED, 5'd5));
      cmd_queue.push_back(make_cmd(lit_pkg::CMD_DEF, 8'd2, 16'hFFFF, 16'h0000,
                                   lit_pkg::OP_FIXED, 5'd31));
      cmd_queue.push_back(make_cmd(lit_pkg::CMD_USE, 8'd2, 16'hFFFF, 16'hFFFF,
                                   lit_pkg::OP_FIXED, 5'd0));
      cmd_queue.push_back(make_cmd(lit_pkg::CMD_READ, 8'd2, 16'd0, 16'd0,
                                   lit_pkg::OP_VIRT, 5'd0));
      cmd_queue.push_back(make_cmd(lit_pkg::CMD_DEF, 8'd2, 16'd7, 16'd7,
                                   lit_pkg::OP_VIRT, 5'd3));
      cmd_queue.push_back(make_cmd(lit_pkg::CMD_USE, 8'd3, 16'd10, 16'd20, OP_REAL_REG, 5'd4));
      cmd_queue.push_back(make_cmd(lit_pkg::CMD_DEF, 8'd3, 16'd10, 16'd20, OP_UNDEF, 5'd4));
      cmd_queue.push_back(make_cmd(lit_pkg::CMD_READ, 8'd3, 16'd0, 16'd0,
                                   lit_pkg::OP_VIRT, 5'd0));
      cmd_queue.push_back(make_cmd(CMD_UNUSED_FIRST, 8'd255, 16'hFFFF, 16'hFFFF, OP_UNDEF,
                                   5'd31));
      cmd_queue.push_back(make_cmd(CMD_UNUSED_LAST, 8'd1, 16'hFFFF, 16'hFFFF,
                                   lit_pkg::OP_FIXED, 5'd31));
      cmd_queue.push_back(make_cmd(lit_pkg::CMD_DEF, 8'd1, 16'd0, 16'd5,
                                   lit_pkg::OP_VIRT, 5'd0));
      cmd_queue.push_back(make_cmd(lit_pkg::CMD_READ, 8'd1, 16'd0, 16'd0,
                                   lit_pkg::OP_VIRT, 5'd0));
      cmd_queue.push_back(make_cmd(lit_pkg::CMD_CLEAR, 8'd0, 16'd0, 16'd0,
                                   lit_pkg::OP_VIRT, 5'd0));
      cmd_queue.push_back(make_cmd(lit_pkg::CMD_READ, 8'd1, 16'd0, 16'd0,
                                   lit_pkg::OP_VIRT, 5'd0));
      cmd_queue.push_back(make_cmd(lit_pkg::CMD_READ, 8'd2, 16'd0, 16'd0,
                                   lit_pkg::OP_VIRT, 5'd0));
      cmd_queue.push_back(make_cmd(lit_pkg::CMD_USE, 8'd4, 16'd30, 16'd40,
                                   lit_pkg::OP_FIXED, 5'd9));
      cmd_queue.push_back(make_cmd(lit_pkg::CMD_READ, 8'd4, 16'd0, 16'd0,
                                   lit_pkg::OP_VIRT, 5'd0));

      for (int n = 0; n < 550; n++) begin
         if (n % 64 == 0) begin
            foreach (pool[k]) pool[k] = 8'($urandom_range(0, 255));
         end
         pick = int'($urandom_range(0, 99));
         if (pick < 1) op = lit_pkg::CMD_CLEAR;
         else if (pick < 24) op = lit_pkg::CMD_LIVE_OUT;
         else if (pick < 50) op = lit_pkg::CMD_USE;
         else if (pick < 66) op = lit_pkg::CMD_DEF;
         else if (pick < 97) op = lit_pkg::CMD_READ;
         else op = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));

         slot = int'($urandom_range(0, 7));
         lo = 16'($urandom);
         hi = 16'($urandom);
         case ($urandom_range(0, 9))
            0: lo = '0;
            1: hi = '1;
            2: lo = hi;
            default: ;
         endcase
         if ($urandom_range(0, 3) != 0 && lo > hi) begin
            tmp = lo;
            lo = hi;
            hi = tmp;
         end

         pick = int'($urandom_range(0, 99));
         if (pick < 80) kind = slot[0] ? lit_pkg::OP_FIXED : lit_pkg::OP_VIRT;
         else if (pick < 92) kind = slot[0] ? lit_pkg::OP_VIRT : lit_pkg::OP_FIXED;
         else if (pick < 96) kind = OP_REAL_REG;
         else kind = OP_UNDEF;

         c = make_cmd(op, ($urandom_range(0, 99) < 85) ? pool[slot] : 8'($urandom),
                      lo, hi, kind, 5'($urandom));
         pick = int'($urandom_range(0, 99));
         if (n >= 200 && n < 260) c.gap = 0;
         else if (pick < 60) c.gap = 0;
         else if (pick < 90) c.gap = int'($urandom_range(1, 3));
         else if (pick < 98) c.gap = int'($urandom_range(4, 10));
         else c.gap = int'($urandom_range(20, 60));
         c.drain = (n % 90 == 0);
         cmd_queue.push_back(c);
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (cmd_queue.size() != 0 || start || pending_reports.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
